// ----- sv/cc20_pkg.sv -----
// package: shared types and constants for the chacha20 stream cipher core
`timescale 1ns / 1ps
package cc20_pkg;
    localparam logic [31:0] C_SIGMA0 = 32'h61707865;
    localparam logic [31:0] C_SIGMA1 = 32'h3320646E;
    localparam logic [31:0] C_SIGMA2 = 32'h79622D32;
    localparam logic [31:0] C_SIGMA3 = 32'h6B206574;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;

    // request held in the queue between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_req;

    // key and nonce as seen by the block engine
    typedef struct packed {
        logic [255:0] key;
        logic [95:0]  nonce;
    } t_cfg;

    typedef logic [31:0] t_word;
    typedef t_word [15:0] t_state;
endpackage

// ----- sv/cc20_front.sv -----
// front part: input request queue
`timescale 1ns / 1ps
module cc20_front
    import cc20_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_q_valid,
    output t_req       o_q_req,
    input  logic       i_q_pop
);
    t_req       r_mem [0:3];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push;

    assign o_stall   = (r_cnt == 3'd4);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 3'd0);
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data: i_data_byte, last: i_last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (i_q_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, i_q_pop};
        end
    end
endmodule

// ----- sv/cc20_core.sv -----
// chacha20 block function: one round step per cycle
`timescale 1ns / 1ps
module cc20_core
    import cc20_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_cfg         i_cfg,
    input  logic [31:0]  i_counter,
    output logic         o_done,
    output logic [511:0] o_block
);
    t_state     r_init, r_work;
    logic [4:0] r_round;
    logic       r_busy, r_done;
    t_state     w_col, w_diag;
    t_state     w_next_init;

    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] qr(input t_word a, input t_word b,
                                        input t_word c, input t_word d);
        t_word ta, tb, tc, td;
        ta = a + b; td = rotl(d ^ ta, 16);
        tc = c + td; tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        qr = {ta, tb, tc, td};
    endfunction

    // even steps are column rounds, odd steps diagonal rounds
    always_comb begin
        w_col  = r_work;
        {w_col[0], w_col[4], w_col[8],  w_col[12]} =
            qr(r_work[0], r_work[4], r_work[8],  r_work[12]);
        {w_col[1], w_col[5], w_col[9],  w_col[13]} =
            qr(r_work[1], r_work[5], r_work[9],  r_work[13]);
        {w_col[2], w_col[6], w_col[10], w_col[14]} =
            qr(r_work[2], r_work[6], r_work[10], r_work[14]);
        {w_col[3], w_col[7], w_col[11], w_col[15]} =
            qr(r_work[3], r_work[7], r_work[11], r_work[15]);
        w_diag = r_work;
        {w_diag[0], w_diag[5], w_diag[10], w_diag[15]} =
            qr(r_work[0], r_work[5], r_work[10], r_work[15]);
        {w_diag[1], w_diag[6], w_diag[11], w_diag[12]} =
            qr(r_work[1], r_work[6], r_work[11], r_work[12]);
        {w_diag[2], w_diag[7], w_diag[8],  w_diag[13]} =
            qr(r_work[2], r_work[7], r_work[8],  r_work[13]);
        {w_diag[3], w_diag[4], w_diag[9],  w_diag[14]} =
            qr(r_work[3], r_work[4], r_work[9],  r_work[14]);
    end

    always_comb begin
        w_next_init[0] = C_SIGMA0;
        w_next_init[1] = C_SIGMA1;
        w_next_init[2] = C_SIGMA2;
        w_next_init[3] = C_SIGMA3;
        for (int i = 0; i < 8; i++) w_next_init[4 + i] = i_cfg.key[32 * i +: 32];
        w_next_init[12] = i_counter;
        w_next_init[13] = i_cfg.nonce[31:0];
        w_next_init[14] = i_cfg.nonce[63:32];
        w_next_init[15] = i_cfg.nonce[95:64];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_init <= w_next_init;
            r_work <= w_next_init;
        end else if (r_busy) begin
            r_work <= r_round[0] ? w_diag : w_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 5'd1;
                if (r_round == 5'd19) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    always_comb begin
        for (int i = 0; i < 16; i++) o_block[32 * i +: 32] = r_work[i] + r_init[i];
    end
endmodule

// ----- sv/cc20_back.sv -----
// back part: keystream buffer, counter and output register
`timescale 1ns / 1ps
module cc20_back
    import cc20_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_req         i_q_req,
    output logic         o_q_pop,
    output logic         o_start,
    output logic [31:0]  o_counter,
    input  logic         i_done,
    input  logic [511:0] i_block,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [7:0]   o_out_byte,
    output logic         o_out_last
);
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    logic [1:0]   r_st;
    logic [31:0]  r_ctr;
    logic [5:0]   r_pos;
    logic [511:0] r_ks;
    logic         r_ov;
    logic [7:0]   r_ob;
    logic         r_ol;
    logic         w_room;

    assign w_room    = !r_ov || !i_stall;
    assign o_q_pop   = (r_st == ST_READY) && i_q_valid && w_room;
    assign o_start   = (r_st == ST_EMPTY) && i_q_valid;
    assign o_counter = r_ctr;
    assign o_valid   = r_ov;
    assign o_out_byte = r_ob;
    assign o_out_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (i_done) r_ks <= i_block;
        if (o_q_pop) begin
            r_ob <= i_q_req.data ^ r_ks[{r_pos, 3'b000} +: 8];
            r_ol <= i_q_req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_EMPTY;
            r_ctr <= '0;
            r_pos <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (o_q_pop) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_st)
                ST_EMPTY: if (o_start) r_st <= ST_CALC;
                ST_CALC: if (i_done) begin
                    r_st  <= ST_READY;
                    r_ctr <= r_ctr + 32'd1;
                end
                ST_READY: if (o_q_pop) begin
                    r_pos <= r_pos + 6'd1;
                    if (i_q_req.last) begin
                        r_ctr <= '0;
                        r_pos <= '0;
                        r_st  <= ST_EMPTY;
                    end else if (r_pos == 6'd63) begin
                        r_st <= ST_EMPTY;
                    end
                end
                default: r_st <= ST_EMPTY;
            endcase
        end
    end
endmodule

// ----- sv/chacha20_stream_cipher_core.sv -----
// top level: chacha20 byte stream cipher core
`timescale 1ns / 1ps
// usage
// - input channel i_valid/o_stall carries one byte request with a last flag
// - output channel o_valid/i_stall returns the byte xored with keystream
// - key and nonce are written through i_cfg_we/i_cfg_addr/i_cfg_data while idle
// - a four-entry queue decouples request intake from the keystream back end
// timing and throughput
// - in a ready block a request passes the queue and then the output register
//   before its result shows; one byte per cycle inside a block unless stalled
// - at the start of every 64-byte block the back end waits for the block
//   function, which runs one round per cycle; the next block is computed only
//   once the current one is used up, so the round unit sets the block rate
// reset
// - synchronous active-low reset clears counter, position, queue and valid;
//   key and nonce registers read zero after reset
// stall
// - a stalled result holds; the queue fills and then o_stall rises
module chacha20_stream_cipher_core
    import cc20_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data
);
    // configuration registers
    logic [63:0] r_key0, r_key1, r_key2, r_key3, r_non0;
    logic [31:0] r_non1;
    t_cfg        w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0; r_key1 <= '0; r_key2 <= '0; r_key3 <= '0;
            r_non0 <= '0; r_non1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KEY0:   r_key0 <= i_cfg_data;
                REG_KEY1:   r_key1 <= i_cfg_data;
                REG_KEY2:   r_key2 <= i_cfg_data;
                REG_KEY3:   r_key3 <= i_cfg_data;
                REG_NONCE0: r_non0 <= i_cfg_data;
                REG_NONCE1: r_non1 <= i_cfg_data[31:0];
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    assign w_cfg.key   = {r_key3, r_key2, r_key1, r_key0};
    assign w_cfg.nonce = {r_non1, r_non0};

    // queue between front and back
    logic         w_q_valid, w_q_pop, w_start, w_done;
    t_req         w_q_req;
    logic [31:0]  w_counter;
    logic [511:0] w_block;

    cc20_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_q_valid(w_q_valid), .o_q_req(w_q_req), .i_q_pop(w_q_pop)
    );

    // block function unit
    cc20_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(w_start), .i_cfg(w_cfg), .i_counter(w_counter),
        .o_done(w_done), .o_block(w_block)
    );

    // keystream application and output register
    cc20_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_q_valid), .i_q_req(w_q_req), .o_q_pop(w_q_pop),
        .o_start(w_start), .o_counter(w_counter),
        .i_done(w_done), .i_block(w_block),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_byte(o_out_byte), .o_out_last(o_out_last)
    );
endmodule

// ----- tb/sv/tb.sv -----
// testbench for the chacha20 byte stream cipher core
`timescale 1ns / 1ps
module tb;
    import cc20_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [63:0] i_cfg_data;

    chacha20_stream_cipher_core dut (.*);

    // shadow of the key and nonce registers
    logic [63:0] key_words [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;

    // shadow of the keystream position
    logic [31:0] blk_count;
    t_state      cur_block;
    logic [5:0]  byte_pos;
    logic        have_block;

    t_req        pending_reqs [$];
    t_req        expected_out [$];

    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_count;
    logic        feed_done;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // safety net; every 64-byte block also waits for the block function, plus stalls
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_state chacha_block(logic [31:0] ctr);
        t_state init_s;
        t_state w;
        int     qa [8];
        int     qb [8];
        int     qc [8];
        int     qd [8];
        qa = '{0, 1, 2, 3, 0, 1, 2, 3};
        qb = '{4, 5, 6, 7, 5, 6, 7, 4};
        qc = '{8, 9, 10, 11, 10, 11, 8, 9};
        qd = '{12, 13, 14, 15, 15, 12, 13, 14};
        init_s[0] = C_SIGMA0;
        init_s[1] = C_SIGMA1;
        init_s[2] = C_SIGMA2;
        init_s[3] = C_SIGMA3;
        for (int i = 0; i < 8; i++)
            init_s[4 + i] = 32'(key_words[i >> 1] >> (32 * (i & 1)));
        init_s[12] = ctr;
        init_s[13] = nonce_lo[31:0];
        init_s[14] = nonce_lo[63:32];
        init_s[15] = nonce_hi;
        w = init_s;
        for (int r = 0; r < 10; r++) begin
            for (int q = 0; q < 8; q++) begin
                w[qa[q]] += w[qb[q]]; w[qd[q]] = rotl(w[qd[q]] ^ w[qa[q]], 16);
                w[qc[q]] += w[qd[q]]; w[qb[q]] = rotl(w[qb[q]] ^ w[qc[q]], 12);
                w[qa[q]] += w[qb[q]]; w[qd[q]] = rotl(w[qd[q]] ^ w[qa[q]], 8);
                w[qc[q]] += w[qd[q]]; w[qb[q]] = rotl(w[qb[q]] ^ w[qc[q]], 7);
            end
        end
        for (int i = 0; i < 16; i++)
            w[i] = w[i] + init_s[i];
        return w;
    endfunction

    // keystream byte for one accepted request, advancing the shadow position
    function automatic t_req encrypt_byte(t_req r);
        t_req  res;
        logic [31:0] word;
        if (!have_block) begin
            cur_block  = chacha_block(blk_count);
            have_block = 1'b1;
            blk_count  = blk_count + 32'd1;
        end
        word = cur_block[byte_pos[5:2]];
        res.data = r.data ^ word[8 * byte_pos[1:0] +: 8];
        res.last = r.last;
        byte_pos = byte_pos + 6'd1;
        if (byte_pos == 6'd0)
            have_block = 1'b0;
        if (r.last) begin
            blk_count  = '0;
            byte_pos   = '0;
            have_block = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // driver: present requests from the queue, holding each until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_out.push_back(encrypt_byte('{i_data_byte, i_last_byte}));
            if (!(i_valid && o_stall)) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_req nx;
                    nx = pending_reqs.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= nx.data;
                    i_last_byte <= nx.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_out.size() == 0) begin
                    report_mismatch("unexpected result", o_out_byte, 8'd0);
                end else begin
                    t_req ex;
                    ex = expected_out.pop_front();
                    if (o_out_byte !== ex.data)
                        report_mismatch("out_byte", o_out_byte, ex.data);
                    if (o_out_last !== ex.last)
                        report_mismatch("out_last", {7'd0, o_out_last}, {7'd0, ex.last});
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_out.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_KEY0:   key_words[0] = val;
            REG_KEY1:   key_words[1] = val;
            REG_KEY2:   key_words[2] = val;
            REG_KEY3:   key_words[3] = val;
            REG_NONCE0: nonce_lo = val;
            REG_NONCE1: nonce_hi = val[31:0];
            default: ;
        endcase
    endtask

    task automatic load_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                            logic [63:0] k3, logic [63:0] n0, logic [63:0] n1);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE0, n0);
        write_reg(REG_NONCE1, n1);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random messages: mostly short, a few spanning several blocks
    task automatic queue_messages(int n_bytes);
        int left;
        int len;
        left = n_bytes;
        while (left > 0) begin
            case ($urandom_range(9))
                0:       len = $urandom_range(130, 200);
                1, 2:    len = $urandom_range(60, 70);
                default: len = $urandom_range(1, 20);
            endcase
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                pending_reqs.push_back('{8'($urandom), (i == len - 1)});
            left -= len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_data_byte   = '0;
        i_last_byte   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count    = 0;
        key_words     = '{default: '0};
        nonce_lo      = '0;
        nonce_hi      = '0;
        blk_count     = '0;
        byte_pos      = '0;
        have_block    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset key, extremes of data, a 1-byte message, an all-ones key
        pending_reqs.push_back('{8'h00, 1'b1});
        pending_reqs.push_back('{8'hFF, 1'b0});
        pending_reqs.push_back('{8'hA5, 1'b1});
        wait_drained();
        load_all('1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 20; i++)
            pending_reqs.push_back('{(i & 1) ? 8'hFF : 8'h00, (i == 19)});
        wait_drained();
        // rfc 7539 style key 00..1f with a fixed nonce, then random messages
        load_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                 64'h4a00000000000000, 64'h0);
        queue_messages(150);
        wait_drained();

        // random phases with various idling, fresh key and nonce each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            load_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
            queue_messages(200);
            wait_drained();
            // second half after a full drain, same settings
            queue_messages(220);
            wait_drained();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
